>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker file of the glyph pixel writer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define FGPW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expr must never be true outside reset
`define FGPW_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> src/fgpw_pkg.sv
// ----------------------------------------------------------------------------
// fgpw_pkg
// Types, constants and the 5x8 column font for the glyph pixel writer.
// ----------------------------------------------------------------------------
`default_nettype none

package fgpw_pkg;

    localparam int GLYPH_WIDTH  = 5;
    localparam int GLYPH_HEIGHT = 8;
    localparam int ADDR_BITS    = 20;
    localparam int GLYPH_COUNT  = 96;
    localparam int GLYPH_BITS   = GLYPH_WIDTH * 8;

    localparam int CODE_W  = 8;
    localparam int POS_W   = 8;
    localparam int COLOR_W = 8;
    localparam int COORD_W = 12;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 1;
    localparam int XBASE_W = 13;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int GIDX_W  = 7;
    localparam int ROMA_W  = 9;
    localparam int CNT_W   = 3;

    localparam logic [CODE_W-1:0] FIRST_CODE = 8'h20;
    localparam logic [CODE_W-1:0] LAST_CODE  = 8'h7f;
    localparam logic [CFG_W-1:0]  PITCH_RESET  = 12'd512;
    localparam logic [CFG_W-1:0]  HEIGHT_RESET = 12'd64;
    localparam logic [CNT_W-1:0]  COL_LAST = CNT_W'(GLYPH_WIDTH - 1);
    localparam logic [CNT_W-1:0]  ROW_LAST = CNT_W'(GLYPH_HEIGHT - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_PITCH    = 1'b0,
        CFG_LAYER_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic last;
    } dp_status_t;

    localparam logic [7:0] FONT_ROM [0:GLYPH_COUNT*GLYPH_WIDTH-1] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5f,8'h00,8'h00,
        8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7f,8'h14,8'h7f,8'h14,
        8'h24,8'h2a,8'h7f,8'h2a,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
        8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00,
        8'h00,8'h1c,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1c,8'h00,
        8'h14,8'h08,8'h3e,8'h08,8'h14, 8'h08,8'h08,8'h3e,8'h08,8'h08,
        8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
        8'h00,8'h60,8'h60,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
        8'h3e,8'h51,8'h49,8'h45,8'h3e, 8'h00,8'h42,8'h7f,8'h40,8'h00,
        8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4b,8'h31,
        8'h18,8'h14,8'h12,8'h7f,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
        8'h3c,8'h4a,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
        8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1e,
        8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,
        8'h08,8'h14,8'h22,8'h41,8'h00, 8'h11,8'h11,8'h11,8'h11,8'h11,
        8'h00,8'h41,8'h22,8'h14,8'h08, 8'h02,8'h01,8'h51,8'h09,8'h06,
        8'h32,8'h49,8'h79,8'h41,8'h3e, 8'h7e,8'h11,8'h11,8'h11,8'h7e,
        8'h7f,8'h49,8'h49,8'h49,8'h36, 8'h3e,8'h41,8'h41,8'h41,8'h22,
        8'h7f,8'h41,8'h41,8'h22,8'h1c, 8'h7f,8'h49,8'h49,8'h49,8'h41,
        8'h7f,8'h09,8'h09,8'h09,8'h01, 8'h3e,8'h41,8'h49,8'h49,8'h7a,
        8'h7f,8'h08,8'h08,8'h08,8'h7f, 8'h00,8'h41,8'h7f,8'h41,8'h00,
        8'h20,8'h40,8'h41,8'h3f,8'h01, 8'h7f,8'h08,8'h14,8'h22,8'h41,
        8'h7f,8'h40,8'h40,8'h40,8'h40, 8'h7f,8'h02,8'h0c,8'h02,8'h7f,
        8'h7f,8'h04,8'h08,8'h10,8'h7f, 8'h3e,8'h41,8'h41,8'h41,8'h3e,
        8'h7f,8'h09,8'h09,8'h09,8'h06, 8'h3e,8'h41,8'h51,8'h21,8'h5e,
        8'h7f,8'h09,8'h19,8'h29,8'h46, 8'h46,8'h49,8'h49,8'h49,8'h31,
        8'h01,8'h01,8'h7f,8'h01,8'h01, 8'h3f,8'h40,8'h40,8'h40,8'h3f,
        8'h1f,8'h20,8'h40,8'h20,8'h1f, 8'h3f,8'h40,8'h38,8'h40,8'h3f,
        8'h63,8'h14,8'h08,8'h14,8'h63, 8'h07,8'h08,8'h70,8'h08,8'h07,
        8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h7f,8'h41,8'h41,8'h00,
        8'h02,8'h04,8'h08,8'h10,8'h20, 8'h00,8'h41,8'h41,8'h7f,8'h00,
        8'h04,8'h02,8'h01,8'h02,8'h04, 8'h40,8'h40,8'h40,8'h40,8'h40,
        8'h00,8'h01,8'h02,8'h04,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
        8'h7f,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20,
        8'h38,8'h44,8'h44,8'h48,8'h7f, 8'h38,8'h54,8'h54,8'h54,8'h18,
        8'h08,8'h7e,8'h09,8'h01,8'h02, 8'h0c,8'h52,8'h52,8'h52,8'h3e,
        8'h7f,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7d,8'h40,8'h00,
        8'h20,8'h40,8'h44,8'h3d,8'h00, 8'h7f,8'h10,8'h28,8'h44,8'h00,
        8'h00,8'h41,8'h7f,8'h40,8'h00, 8'h7c,8'h04,8'h18,8'h04,8'h78,
        8'h7c,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38,
        8'h7c,8'h14,8'h14,8'h14,8'h08, 8'h08,8'h14,8'h14,8'h18,8'h7c,
        8'h7c,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
        8'h04,8'h3f,8'h44,8'h40,8'h20, 8'h3c,8'h40,8'h40,8'h20,8'h7c,
        8'h1c,8'h20,8'h40,8'h20,8'h1c, 8'h3c,8'h40,8'h30,8'h40,8'h3c,
        8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0c,8'h50,8'h50,8'h50,8'h3c,
        8'h44,8'h64,8'h54,8'h4c,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00,
        8'h00,8'h00,8'h7f,8'h00,8'h00, 8'h00,8'h41,8'h36,8'h08,8'h00,
        8'h10,8'h08,8'h08,8'h10,8'h08, 8'h78,8'h46,8'h41,8'h46,8'h78
    };

    // map a character code to its glyph, codes outside 0x20..0x7f draw as space
    function automatic logic [GIDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] rel;
        rel = code - FIRST_CODE;
        if (code < FIRST_CODE || code > LAST_CODE)
        begin
            return '0;
        end
        return rel[GIDX_W-1:0];
    endfunction

    // all columns of a glyph, column c in bits [8c+7:8c]
    function automatic logic [GLYPH_BITS-1:0] glyph_columns(input logic [GIDX_W-1:0] idx);
        logic [ROMA_W-1:0]     base;
        logic [GLYPH_BITS-1:0] cols;
        base = ROMA_W'(idx) * ROMA_W'(GLYPH_WIDTH);
        cols = '0;
        for (int c = 0; c < GLYPH_WIDTH; c++)
        begin
            cols[c*8 +: 8] = FONT_ROM[base + ROMA_W'(c)];
        end
        return cols;
    endfunction

endpackage

`default_nettype wire

>>> src/fgpw_if.sv
// ----------------------------------------------------------------------------
// fgpw_if
// Request channels of the glyph pixel writer: characters in, pixel writes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fgpw_char_if
    import fgpw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CODE_W-1:0]  char_code;
    logic [POS_W-1:0]   char_position;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;

    modport source (
        output valid, char_code, char_position, fg_color, bg_color, origin_x, origin_y,
        input  ready
    );
    modport sink (
        input  valid, char_code, char_position, fg_color, bg_color, origin_x, origin_y,
        output ready
    );
endinterface

interface fgpw_pix_if
    import fgpw_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] pixel_address;
    logic [COLOR_W-1:0]   pixel_color;
    logic                 last_pixel;

    modport source (
        output valid, pixel_address, pixel_color, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_address, pixel_color, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

>>> src/fgpw_ctrl.sv
// ----------------------------------------------------------------------------
// fgpw_ctrl
// Sequencer: takes one character request, sets up, then steps the pixel writes (none if skipped).
// ----------------------------------------------------------------------------
`default_nettype none

module fgpw_ctrl
    import fgpw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output dp_cmd_t         cmd,
    input  wire dp_status_t status
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = status.skip ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SETUP:
            begin
                cmd.setup = !status.skip;
            end
            ST_EMIT:
            begin
                out_valid   = 1'b1;
                cmd.advance = out_ready;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/fgpw_datapath.sv
// ----------------------------------------------------------------------------
// fgpw_datapath
// Config registers, glyph fetch, address arithmetic and pixel counters.
// ----------------------------------------------------------------------------
`default_nettype none

module fgpw_datapath
    import fgpw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status,
    input  wire logic [CODE_W-1:0]    char_code,
    input  wire logic [POS_W-1:0]     char_position,
    input  wire logic [COLOR_W-1:0]   fg_color,
    input  wire logic [COLOR_W-1:0]   bg_color,
    input  wire logic [COORD_W-1:0]   origin_x,
    input  wire logic [COORD_W-1:0]   origin_y,
    output logic [ADDR_BITS-1:0]      pixel_address,
    output logic [COLOR_W-1:0]        pixel_color,
    output logic                      last_pixel
);

    logic [CFG_W-1:0]      pitch_reg;
    logic [CFG_W-1:0]      height_reg;
    logic [GLYPH_BITS-1:0] glyph_reg;
    logic [COLOR_W-1:0]    fg_reg;
    logic [COLOR_W-1:0]    bg_reg;
    logic [XBASE_W-1:0]    xbase_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  skip_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [ADDR_BITS-1:0]  row_addr_reg;
    logic [CNT_W-1:0]      col_reg;
    logic [CNT_W-1:0]      row_reg;
    logic [ADDR_BITS-1:0]  row_addr_next;
    logic [XBASE_W-1:0]    pos_times_w;
    logic                  col_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg  <= PITCH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ROW_PITCH:    pitch_reg  <= cfg_data;
                CFG_LAYER_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    assign pos_times_w = XBASE_W'(char_position) * XBASE_W'(GLYPH_WIDTH);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            glyph_reg <= glyph_columns(glyph_index(char_code));
            fg_reg    <= fg_color;
            bg_reg    <= bg_color;
            xbase_reg <= XBASE_W'(origin_x) + pos_times_w;
            prod_reg  <= PROD_W'(origin_y) * PROD_W'(pitch_reg);
            skip_reg  <= origin_y > height_reg;
        end
    end

    assign col_end       = col_reg == COL_LAST;
    assign row_addr_next = row_addr_reg + ADDR_BITS'(pitch_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.setup)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.advance)
        begin
            col_reg <= col_end ? '0 : col_reg + 1'b1;
            if (col_end)
            begin
                row_reg <= row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            addr_reg     <= prod_reg[ADDR_BITS-1:0] + ADDR_BITS'(xbase_reg);
            row_addr_reg <= prod_reg[ADDR_BITS-1:0] + ADDR_BITS'(xbase_reg);
        end
        else if (cmd.advance)
        begin
            if (col_end)
            begin
                addr_reg     <= row_addr_next;
                row_addr_reg <= row_addr_next;
            end
            else
            begin
                addr_reg <= addr_reg + 1'b1;
            end
        end
    end

    assign pixel_address = addr_reg;
    assign pixel_color   = glyph_reg[{col_reg, row_reg}] ? fg_reg : bg_reg;
    assign last_pixel    = col_end && (row_reg == ROW_LAST);
    assign status.skip   = skip_reg;
    assign status.last   = last_pixel;

endmodule

`default_nettype wire

>>> src/font_glyph_pixel_writer.sv
// ----------------------------------------------------------------------------
// font_glyph_pixel_writer
// Draws one 5x8 font character per request as a run of framebuffer writes.
//
//   Channel   Role    Payload
//   char_in   sink    char_code, char_position, fg_color, bg_color, origin_x/y
//   pix_out   source  pixel_address, pixel_color, last_pixel
//   cfg       write   cfg_index 0 row_pitch, 1 layer_height
//
// A character is accepted, set up, then drawn as 40 writes at one per cycle
// while the output does not stall, from the single address/counter datapath.
// A character below the layer height ends after setup with no write.
// One character at a time; output stalls hold the current write.
// Reset clears the sequencer and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module font_glyph_pixel_writer
    import fgpw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    fgpw_char_if.sink                 char_in,
    fgpw_pix_if.source                pix_out
);

    dp_cmd_t    cmd;
    dp_status_t status;

    fgpw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (char_in.valid),
        .in_ready  (char_in.ready),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .cmd       (cmd),
        .status    (status)
    );

    fgpw_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .char_code     (char_in.char_code),
        .char_position (char_in.char_position),
        .fg_color      (char_in.fg_color),
        .bg_color      (char_in.bg_color),
        .origin_x      (char_in.origin_x),
        .origin_y      (char_in.origin_y),
        .pixel_address (pix_out.pixel_address),
        .pixel_color   (pix_out.pixel_color),
        .last_pixel    (pix_out.last_pixel)
    );

endmodule

`default_nettype wire

>>> src/fgpw_checker.sv
// ----------------------------------------------------------------------------
// fgpw_checker
// Port-level checks of the glyph pixel writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fgpw_checker
    import fgpw_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [ADDR_BITS-1:0] pixel_address,
    input wire logic [COLOR_W-1:0]   pixel_color,
    input wire logic                 last_pixel
);

    `FGPW_NEVER(a_one_request, in_ready && out_valid, "input taken while writes pending")
    `FGPW_ASSERT(a_in_then_busy, (in_valid && in_ready) |=> !in_ready, "second request taken")
    `FGPW_ASSERT(a_last_ends, (out_valid && out_ready && last_pixel) |=> !out_valid, "write after last")
    `FGPW_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(pixel_address) && $stable(pixel_color) && $stable(last_pixel)), "stalled write changed")

endmodule

bind font_glyph_pixel_writer fgpw_checker u_fgpw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (char_in.valid),
    .in_ready      (char_in.ready),
    .out_valid     (pix_out.valid),
    .out_ready     (pix_out.ready),
    .pixel_address (pix_out.pixel_address),
    .pixel_color   (pix_out.pixel_color),
    .last_pixel    (pix_out.last_pixel)
);

`default_nettype wire
